FILE: design/qau_pkg.sv
// Shared types and constants for the quaternion arithmetic unit.
package qau_pkg;

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_SUB   = 3'd1,
    FN_HAM   = 3'd2,
    FN_SCALE = 3'd3,
    FN_DIV   = 3'd4,
    FN_CONJ  = 3'd5,
    FN_MAG   = 3'd6,
    FN_NORM  = 3'd7
  } func_t;

  typedef logic [1:0] qidx_t;

  typedef struct packed {
    logic ovf;
    logic err;
  } lane_flags_t;

  // Hamilton product: term i of component k is a[HAM_AI[k][i]] * b[i]
  localparam qidx_t HAM_AI [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // bit i set: term i is subtracted
  localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b0100, 4'b1000, 4'b0010};

endpackage

FILE: design/qau_delay.sv
// Fixed-length shift line for aligning side data with the pipeline.
module qau_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    pipe_r[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign q = pipe_r[DEPTH-1];

endmodule

FILE: design/qau_sqrt.sv
// Pipelined sum of squares and integer square root, one root bit per stage.
module qau_sqrt #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic signed [W-1:0] a [4],
  output logic [W:0]          root
);

  localparam int RW   = W + 1;
  localparam int PW   = 2 * W;
  localparam int SQW  = 2 * RW;
  localparam int RMW  = RW + 2;
  localparam int LIMB = (SQW > 64) ? 64 : SQW;
  localparam logic [SQW-1:0] SUM_LIM = (SQW'(1) << LIMB) - SQW'(1);

  logic [PW-1:0]  sq_r [4];
  logic [PW:0]    pr_r [2];
  logic [SQW-1:0] rad_r [RW];
  logic [RMW-1:0] rem_r [RW];
  logic [RW-1:0]  root_r [RW+1];

  logic [W-1:0]   aa [4];
  logic [SQW-1:0] total;
  logic [RMW:0]   step [RW];

  // one restoring step: {ge, new remainder}
  function automatic logic [RMW:0] sq_step(input logic [RMW-1:0] rem,
                                           input logic [1:0] pair,
                                           input logic [RW-1:0] rt);
    logic [RMW+1:0] t;
    logic [RMW+1:0] trial;
    t     = {rem, pair};
    trial = {2'b00, rt, 2'b01};
    if (t >= trial) begin
      return {1'b1, RMW'(t - trial)};
    end
    return {1'b0, RMW'(t)};
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      aa[i] = a[i][W-1] ? W'(-a[i]) : W'(a[i]);
    end
    total = SQW'(pr_r[0]) + SQW'(pr_r[1]);
    for (int k = 0; k < RW; k++) begin
      step[k] = sq_step(rem_r[k], rad_r[k][SQW-1:SQW-2], root_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sq_r[i] <= PW'(aa[i]) * PW'(aa[i]);
    end
    pr_r[0]   <= (PW+1)'(sq_r[0]) + (PW+1)'(sq_r[1]);
    pr_r[1]   <= (PW+1)'(sq_r[2]) + (PW+1)'(sq_r[3]);
    rad_r[0]  <= (total > SUM_LIM) ? SUM_LIM : total;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    for (int k = 1; k < RW; k++) begin
      rad_r[k] <= rad_r[k-1] << 2;
      rem_r[k] <= step[k-1][RMW-1:0];
    end
    for (int k = 1; k <= RW; k++) begin
      root_r[k] <= {root_r[k-1][RW-2:0], step[k-1][RMW]};
    end
  end

  assign root = root_r[RW];

endmodule

FILE: design/qau_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module qau_div #(
  parameter int NW = 28,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_r [NW-1];
  logic [NW-1:0] n_r   [NW-1];
  logic [DW-1:0] den_r [NW-1];
  logic [NW-1:0] q_r   [NW];
  logic [DW:0]   step  [NW];

  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nb,
                                           input logic [DW-1:0] d);
    logic [DW:0] t;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      return {1'b1, DW'(t - {1'b0, d})};
    end
    return {1'b0, DW'(t)};
  endfunction

  always_comb begin
    step[0] = div_step('0, num[NW-1], den);
    for (int j = 1; j < NW; j++) begin
      step[j] = div_step(rem_r[j-1], n_r[j-1][NW-1], den_r[j-1]);
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= step[0][DW-1:0];
    n_r[0]   <= num << 1;
    den_r[0] <= den;
    q_r[0]   <= NW'(step[0][DW]);
    for (int j = 1; j < NW - 1; j++) begin
      rem_r[j] <= step[j][DW-1:0];
      n_r[j]   <= n_r[j-1] << 1;
      den_r[j] <= den_r[j-1];
    end
    for (int j = 1; j < NW; j++) begin
      q_r[j] <= {q_r[j-1][NW-2:0], step[j][DW]};
    end
  end

  assign quo = q_r[NW-1];

endmodule

FILE: design/qau_lane.sv
// One result component: multiply-accumulate path and divide path.
module qau_lane #(
  parameter int W    = 16,
  parameter int F    = 12,
  parameter int LANE = 0
) (
  input  logic                clk,
  input  qau_pkg::func_t      func,
  input  logic signed [W-1:0] a [4],
  input  logic signed [W-1:0] b [4],
  input  logic signed [W-1:0] s,
  input  logic [W:0]          root,
  output logic signed [W-1:0] res,
  output qau_pkg::lane_flags_t flags
);

  localparam int PW = 2 * W;
  localparam int XW = (2 * W + 2 > 64) ? 2 * W + 2 : 64;
  localparam int LS = W + 4;
  localparam int QB = W + F;
  localparam int DW = W + 1;
  localparam int TF = LS + QB;
  localparam logic signed [XW-1:0] LIM  = XW'(1) <<< 61;
  localparam logic signed [XW-1:0] HALF = XW'(1) <<< (F - 1);
  localparam logic signed [XW-1:0] MAXV = (XW'(1) <<< (W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] MINV = -(XW'(1) <<< (W - 1));
  localparam logic [QB-1:0] MAXQ = (QB'(1) << (W - 1)) - QB'(1);
  localparam logic [QB-1:0] MINQ = QB'(1) << (W - 1);
  localparam logic signed [W-1:0] ONE_W = W'(1);

  logic signed [W-1:0]  x [4];
  logic signed [W-1:0]  y [4];
  logic [3:0]           neg;
  logic signed [PW-1:0] p_r [4];
  logic [3:0]           neg_r;
  qau_pkg::func_t       f1_r, f2_r;
  logic signed [XW-1:0] t [4];
  logic signed [XW-1:0] s01_r, s23_r;
  logic signed [XW-1:0] tot, rnd;
  logic signed [W-1:0]  dir_r, dir_nxt;
  logic                 dovf_r, dovf_nxt;

  logic [W:0]           dir_d;
  logic [2*W+2:0]       opd_d;
  logic signed [W-1:0]  a_l, s_l;
  qau_pkg::func_t       f_l, f_f;
  logic [W-1:0]         absa, abss;
  logic [QB-1:0]        num;
  logic [DW-1:0]        den;
  logic                 neg_l, dz_l;
  logic [4:0]           side_d;
  logic [QB-1:0]        quo;

  logic signed [W-1:0]  res_r, res_nxt;
  qau_pkg::lane_flags_t flags_r, flags_nxt;

  function automatic logic signed [XW-1:0] clampw(input logic signed [XW-1:0] v);
    if (v > LIM) begin
      return LIM;
    end
    if (v < -LIM) begin
      return -LIM;
    end
    return v;
  endfunction

  // operand selection for the four multipliers
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      x[i] = '0;
      y[i] = '0;
    end
    neg = '0;
    unique case (func)
      qau_pkg::FN_ADD: begin
        x[0] = a[LANE]; y[0] = ONE_W;
        x[1] = b[LANE]; y[1] = ONE_W;
      end
      qau_pkg::FN_SUB: begin
        x[0] = a[LANE]; y[0] = ONE_W;
        x[1] = b[LANE]; y[1] = ONE_W;
        neg[1] = 1'b1;
      end
      qau_pkg::FN_HAM: begin
        for (int i = 0; i < 4; i++) begin
          x[i] = a[qau_pkg::HAM_AI[LANE][i]];
          y[i] = b[i];
        end
        neg = qau_pkg::HAM_NEG[LANE];
      end
      qau_pkg::FN_SCALE: begin
        x[0] = a[LANE]; y[0] = s;
      end
      qau_pkg::FN_CONJ: begin
        x[0] = a[LANE]; y[0] = ONE_W;
        neg[0] = (LANE != 0);
      end
      qau_pkg::FN_DIV, qau_pkg::FN_MAG, qau_pkg::FN_NORM: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t[i] = neg_r[i] ? -clampw(XW'(p_r[i])) : clampw(XW'(p_r[i]));
    end
    tot = clampw(s01_r + s23_r);
    rnd = (f2_r == qau_pkg::FN_HAM || f2_r == qau_pkg::FN_SCALE) ?
          ((tot + HALF) >>> F) : tot;
    dovf_nxt = 1'b0;
    if (rnd > MAXV) begin
      dir_nxt  = MAXV[W-1:0];
      dovf_nxt = 1'b1;
    end else if (rnd < MINV) begin
      dir_nxt  = MINV[W-1:0];
      dovf_nxt = 1'b1;
    end else begin
      dir_nxt = rnd[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      p_r[i] <= PW'(x[i]) * PW'(y[i]);
    end
    neg_r  <= neg;
    f1_r   <= func;
    s01_r  <= clampw(t[0] + t[1]);
    s23_r  <= clampw(t[2] + t[3]);
    f2_r   <= f1_r;
    dir_r  <= dir_nxt;
    dovf_r <= dovf_nxt;
  end

  qau_delay #(.WIDTH(W + 1), .DEPTH(TF - 3)) u_dir (
    .clk (clk),
    .d   ({dir_r, dovf_r}),
    .q   (dir_d)
  );

  // hold the divide operands until the root is out
  qau_delay #(.WIDTH(2 * W + 3), .DEPTH(LS)) u_opd (
    .clk (clk),
    .d   ({a[LANE], s, func}),
    .q   (opd_d)
  );

  always_comb begin
    a_l  = opd_d[2*W+2:W+3];
    s_l  = opd_d[W+2:3];
    f_l  = qau_pkg::func_t'(opd_d[2:0]);
    absa = a_l[W-1] ? W'(-a_l) : W'(a_l);
    abss = s_l[W-1] ? W'(-s_l) : W'(s_l);
    num  = {absa, F'(0)};
    if (f_l == qau_pkg::FN_DIV) begin
      den   = {1'b0, abss};
      neg_l = a_l[W-1] ^ s_l[W-1];
    end else begin
      den   = root;
      neg_l = a_l[W-1];
    end
    dz_l = (den == '0);
  end

  qau_div #(.NW(QB), .DW(DW)) u_div (
    .clk (clk),
    .num (num),
    .den (den),
    .quo (quo)
  );

  qau_delay #(.WIDTH(5), .DEPTH(QB)) u_side (
    .clk (clk),
    .d   ({neg_l, dz_l, f_l}),
    .q   (side_d)
  );

  always_comb begin
    f_f       = qau_pkg::func_t'(side_d[2:0]);
    res_nxt   = '0;
    flags_nxt = '0;
    unique case (f_f)
      qau_pkg::FN_ADD, qau_pkg::FN_SUB, qau_pkg::FN_HAM, qau_pkg::FN_SCALE,
      qau_pkg::FN_CONJ: begin
        res_nxt       = dir_d[W:1];
        flags_nxt.ovf = dir_d[0];
      end
      qau_pkg::FN_MAG: begin
      end
      qau_pkg::FN_DIV, qau_pkg::FN_NORM: begin
        if (side_d[3]) begin
          flags_nxt.err = 1'b1;
        end else if (!side_d[4]) begin
          if (quo > MAXQ) begin
            res_nxt       = MAXQ[W-1:0];
            flags_nxt.ovf = 1'b1;
          end else begin
            res_nxt = quo[W-1:0];
          end
        end else begin
          if (quo > MINQ) begin
            res_nxt       = MINQ[W-1:0];
            flags_nxt.ovf = 1'b1;
          end else begin
            res_nxt = -quo[W-1:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    flags_r <= flags_nxt;
  end

  assign res   = res_r;
  assign flags = flags_r;

endmodule

FILE: design/quaternion_arithmetic_unit.sv
// Quaternion ALU in signed fixed point: four component lanes, shared root, merge stage.
//
// Input: drive in_func and the operand ports with start high; a word is taken at
// any rising edge where start is high and busy is low. busy is always low, so a
// new word may be offered every cycle.
// Output: each result is shown for one cycle with out_valid high. The receiver
// cannot stall it, and nothing here needs it to.
// out_valid follows the accepting edge by the same delay for every operation.
// Throughput: one word per cycle. The depth comes from the square-root pipeline
// (one root bit per stage, COMP_WIDTH + 1 stages) feeding the per-lane dividers
// (one quotient bit per stage, COMP_WIDTH + FRAC_BITS stages), which normalise
// needs in series; all other operations are delayed to match so order is kept.
// out_magnitude carries |a| for every operation.
// Reset: rst_n low clears the valid pipeline; words in flight are dropped and no
// strobe is raised until new words are taken.
module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS  = 12,
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_func,
  input  logic signed [COMP_WIDTH-1:0] in_a_w,
  input  logic signed [COMP_WIDTH-1:0] in_a_x,
  input  logic signed [COMP_WIDTH-1:0] in_a_y,
  input  logic signed [COMP_WIDTH-1:0] in_a_z,
  input  logic signed [COMP_WIDTH-1:0] in_b_w,
  input  logic signed [COMP_WIDTH-1:0] in_b_x,
  input  logic signed [COMP_WIDTH-1:0] in_b_y,
  input  logic signed [COMP_WIDTH-1:0] in_b_z,
  input  logic signed [COMP_WIDTH-1:0] in_scalar,
  output logic                         out_valid,
  output logic signed [COMP_WIDTH-1:0] out_r_w,
  output logic signed [COMP_WIDTH-1:0] out_r_x,
  output logic signed [COMP_WIDTH-1:0] out_r_y,
  output logic signed [COMP_WIDTH-1:0] out_r_z,
  output logic [COMP_WIDTH-1:0]        out_magnitude,
  output logic                         out_overflow,
  output logic                         out_error
);

  localparam int W    = COMP_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int LS   = W + 4;
  localparam int QB   = W + F;
  localparam int TF   = LS + QB;
  localparam int NSTG = TF + 3;

  logic [NSTG-1:0]      vld_r;
  qau_pkg::func_t       func_r;
  logic signed [W-1:0]  a_r [4];
  logic signed [W-1:0]  b_r [4];
  logic signed [W-1:0]  s_r;
  logic [W:0]           root_ls, root_m;
  logic [2:0]           fm_bits;
  qau_pkg::func_t       fm;
  logic signed [W-1:0]  lres [4];
  qau_pkg::lane_flags_t lflags [4];

  logic signed [W-1:0]  res_r [4];
  logic [W-1:0]         mag_r, mag_nxt;
  logic                 ovf_r, ovf_nxt, err_r, err_nxt;
  qau_pkg::func_t       fo_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    func_r <= qau_pkg::func_t'(in_func);
    a_r[0] <= in_a_w;
    a_r[1] <= in_a_x;
    a_r[2] <= in_a_y;
    a_r[3] <= in_a_z;
    b_r[0] <= in_b_w;
    b_r[1] <= in_b_x;
    b_r[2] <= in_b_y;
    b_r[3] <= in_b_z;
    s_r    <= in_scalar;
  end

  qau_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .a    (a_r),
    .root (root_ls)
  );

  qau_delay #(.WIDTH(W + 1), .DEPTH(QB + 1)) u_root_dly (
    .clk (clk),
    .d   (root_ls),
    .q   (root_m)
  );

  qau_delay #(.WIDTH(3), .DEPTH(TF + 1)) u_func_dly (
    .clk (clk),
    .d   (func_r),
    .q   (fm_bits)
  );

  assign fm = qau_pkg::func_t'(fm_bits);

  for (genvar g = 0; g < 4; g++) begin : g_lane
    qau_lane #(.W(W), .F(F), .LANE(g)) u_lane (
      .clk   (clk),
      .func  (func_r),
      .a     (a_r),
      .b     (b_r),
      .s     (s_r),
      .root  (root_ls),
      .res   (lres[g]),
      .flags (lflags[g])
    );
  end

  // merge: magnitude saturation and flag collection
  always_comb begin
    mag_nxt = root_m[W] ? '1 : root_m[W-1:0];
    err_nxt = lflags[0].err | lflags[1].err | lflags[2].err | lflags[3].err;
    if (fm == qau_pkg::FN_MAG) begin
      ovf_nxt = root_m[W];
    end else begin
      ovf_nxt = lflags[0].ovf | lflags[1].ovf | lflags[2].ovf | lflags[3].ovf;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      res_r[i] <= lres[i];
    end
    mag_r <= mag_nxt;
    ovf_r <= ovf_nxt;
    err_r <= err_nxt;
    fo_r  <= fm;
  end

  assign out_valid     = vld_r[NSTG-1];
  assign out_r_w       = res_r[0];
  assign out_r_x       = res_r[1];
  assign out_r_y       = res_r[2];
  assign out_r_z       = res_r[3];
  assign out_magnitude = mag_r;
  assign out_overflow  = ovf_r;
  assign out_error     = err_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##NSTG out_valid)
    else $error("result word missing at fixed latency");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_r_w == '0 && out_r_x == '0 && out_r_y == '0
                               && out_r_z == '0 && !out_overflow)
    else $error("error word carries data or overflow");

  a_err_func: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> fo_r == qau_pkg::FN_DIV || fo_r == qau_pkg::FN_NORM)
    else $error("error raised by an operation that cannot fail");

  a_mag_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fo_r == qau_pkg::FN_MAG |-> out_r_w == '0 && out_r_x == '0
                                            && out_r_y == '0 && out_r_z == '0
                                            && !out_error)
    else $error("magnitude word has component data");

  a_norm_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fo_r == qau_pkg::FN_NORM && !out_error |-> out_magnitude != '0)
    else $error("normalise accepted with zero magnitude");

endmodule
